// ===== rtl/btu_pkg.sv =====
package btu_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_INVERT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd2;

  localparam int CFG_DATA_W = 16;
  localparam int TIMER_W    = 16;
  localparam int COUNT_W    = 6;

  localparam logic [TIMER_W-1:0] BIT_TICKS_RST = 16'd104;

  // Frame shape
  localparam logic [3:0] BYTE_BITS = 4'd8;
  localparam logic [3:0] GAP_BITS  = 4'd6;

  typedef struct packed {
    logic       rx_level;
    logic       tx_start;
    logic [7:0] tx_byte;
    logic       rx_pop;
  } in_t;

  typedef struct packed {
    logic               tx_level;
    logic               tx_busy;
    logic [7:0]         rx_byte;
    logic               rx_valid;
    logic [COUNT_W-1:0] rx_count;
    logic               rx_overflow;
  } out_t;

endpackage

// ===== rtl/bit_timed_uart_with_rx_fifo.sv =====
// 8N1 UART stepped once per timer tick, with a receive FIFO. Each request on
// the in_ channel is one tick: the line level seen, an optional transmit start
// and an optional pop; each tick gives exactly one response on the out_ channel
// with the transmit level, busy flag, popped byte, fill count and the sticky
// overflow flag. One tick is taken every clock cycle unless the out_ channel
// stalls; a response passes through the input register, then the register
// holding the updated state and the response. The FIFO memory keeps the byte
// at the head pre-read into a register, refreshed every cycle with a write
// bypass, so pops can follow back to back. It holds FIFO_DEPTH-1 bytes. Write
// configuration only while no request is in flight; changes apply from the
// next tick.
module bit_timed_uart_with_rx_fifo #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  btu_pkg::in_t                         in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output btu_pkg::out_t                        out_data,
  input  logic                                 cfg_we,
  input  logic [btu_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [btu_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import btu_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {RX_IDLE, RX_HALF, RX_DATA, RX_STOP} rx_phase_t;
  typedef enum logic [2:0] {TX_IDLE, TX_START, TX_DATA, TX_STOP, TX_GAP} tx_phase_t;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // configuration
  logic [TIMER_W-1:0] bit_ticks_r;
  logic               line_invert_r;
  logic               enable_r;

  // pipeline control
  logic  s1_vld_r;
  in_t   s1_data_r;
  logic  out_vld_r;
  out_t  out_data_r;
  logic  s2_ready;
  logic  adv;

  // receiver / transmitter state
  rx_phase_t          rx_phase_r, rx_phase_nxt;
  logic [TIMER_W-1:0] rx_timer_r, rx_timer_nxt;
  logic [3:0]         rx_idx_r, rx_idx_nxt;
  logic [7:0]         rx_shift_r, rx_shift_nxt;
  logic               rx_prev_r, rx_prev_nxt;
  tx_phase_t          tx_phase_r, tx_phase_nxt;
  logic [TIMER_W-1:0] tx_timer_r, tx_timer_nxt;
  logic [3:0]         tx_idx_r, tx_idx_nxt;
  logic [7:0]         tx_shift_r, tx_shift_nxt;

  // fifo
  logic [7:0]    mem [FIFO_DEPTH];
  logic [AW-1:0] head_r, head_nxt, head_pop;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    rd_data_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW:0]   cnt_full;

  logic       logical;
  logic       pop_ok;
  logic       push;
  logic [3:0] rx_idx_inc;
  logic [3:0] tx_idx_inc;
  logic       tx_logic;
  out_t       res;

  assign s2_ready  = !out_vld_r || !out_stall;
  assign adv       = s1_vld_r && s2_ready;
  assign in_stall  = s1_vld_r && !s2_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  assign logical    = s1_data_r.rx_level ^ line_invert_r;
  assign rx_idx_inc = rx_idx_r + 4'd1;
  assign tx_idx_inc = tx_idx_r + 4'd1;

  always_comb begin
    rx_phase_nxt = rx_phase_r;
    rx_timer_nxt = rx_timer_r;
    rx_idx_nxt   = rx_idx_r;
    rx_shift_nxt = rx_shift_r;
    rx_prev_nxt  = logical;
    tx_phase_nxt = tx_phase_r;
    tx_timer_nxt = tx_timer_r;
    tx_idx_nxt   = tx_idx_r;
    tx_shift_nxt = tx_shift_r;
    head_pop     = head_r;
    tail_nxt     = tail_r;
    ovf_nxt      = ovf_r;
    pop_ok       = 1'b0;
    push         = 1'b0;
    tx_logic     = 1'b1;

    if (!enable_r) begin
      rx_phase_nxt = RX_IDLE;
      rx_timer_nxt = '0;
      rx_idx_nxt   = '0;
      tx_phase_nxt = TX_IDLE;
      tx_timer_nxt = '0;
      tx_idx_nxt   = '0;
    end else begin
      // pop goes first so it can make room for this tick's push
      if (s1_data_r.rx_pop && (head_r != tail_r)) begin
        pop_ok   = 1'b1;
        head_pop = ring_next(head_r);
      end

      if (rx_phase_r == RX_IDLE) begin
        if (rx_prev_r && !logical) begin
          rx_phase_nxt = RX_HALF;
          rx_timer_nxt = bit_ticks_r >> 1;
          rx_shift_nxt = '0;
          rx_idx_nxt   = '0;
        end
      end else if (rx_timer_r > 16'd1) begin
        rx_timer_nxt = rx_timer_r - 16'd1;
      end else if (rx_phase_r == RX_HALF) begin
        rx_phase_nxt = RX_DATA;
        rx_idx_nxt   = '0;
        rx_timer_nxt = bit_ticks_r;
      end else if (rx_phase_r == RX_DATA) begin
        rx_shift_nxt = {logical, rx_shift_r[7:1]};
        rx_idx_nxt   = rx_idx_inc;
        rx_timer_nxt = bit_ticks_r;
        if (rx_idx_inc >= BYTE_BITS) begin
          rx_phase_nxt = RX_STOP;
          if (ring_next(tail_r) != head_pop) begin
            push     = 1'b1;
            tail_nxt = ring_next(tail_r);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end else begin
        rx_phase_nxt = RX_IDLE;
        rx_timer_nxt = '0;
        rx_idx_nxt   = '0;
      end

      if (tx_phase_r != TX_IDLE) begin
        if (tx_timer_r > 16'd1) begin
          tx_timer_nxt = tx_timer_r - 16'd1;
        end else if (tx_phase_r == TX_START) begin
          tx_phase_nxt = TX_DATA;
          tx_idx_nxt   = '0;
          tx_timer_nxt = bit_ticks_r;
        end else if (tx_phase_r == TX_DATA) begin
          tx_idx_nxt   = tx_idx_inc;
          tx_timer_nxt = bit_ticks_r;
          if (tx_idx_inc >= BYTE_BITS) begin
            tx_phase_nxt = TX_STOP;
          end
        end else if (tx_phase_r == TX_STOP) begin
          tx_phase_nxt = TX_GAP;
          tx_idx_nxt   = '0;
          tx_timer_nxt = bit_ticks_r;
        end else begin
          tx_idx_nxt   = tx_idx_inc;
          tx_timer_nxt = bit_ticks_r;
          if (tx_idx_inc >= GAP_BITS) begin
            tx_phase_nxt = TX_IDLE;
            tx_timer_nxt = '0;
            tx_idx_nxt   = '0;
          end
        end
      end
      // the tick that ends the gap already counts as idle
      if (tx_phase_nxt == TX_IDLE && s1_data_r.tx_start) begin
        tx_phase_nxt = TX_START;
        tx_timer_nxt = bit_ticks_r;
        tx_idx_nxt   = '0;
        tx_shift_nxt = s1_data_r.tx_byte;
      end

      if (tx_phase_nxt == TX_START) begin
        tx_logic = 1'b0;
      end else if (tx_phase_nxt == TX_DATA) begin
        tx_logic = tx_shift_nxt[tx_idx_nxt[2:0]];
      end
    end

    if (tail_nxt >= head_pop) begin
      cnt_full = {1'b0, tail_nxt} - {1'b0, head_pop};
    end else begin
      cnt_full = {1'b0, tail_nxt} + (AW+1)'(FIFO_DEPTH) - {1'b0, head_pop};
    end

    res.tx_level    = tx_logic ^ line_invert_r;
    res.tx_busy     = (tx_phase_nxt != TX_IDLE);
    res.rx_byte     = pop_ok ? rd_data_r : 8'd0;
    res.rx_valid    = pop_ok;
    res.rx_count    = COUNT_W'(cnt_full);
    res.rx_overflow = ovf_nxt;
  end

  assign wr_en    = adv && push;
  assign wr_addr  = tail_r;
  assign wr_data  = rx_shift_nxt;
  assign head_nxt = adv ? head_pop : head_r;

  // byte at the head is always pre-read; bypass a write landing there
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == head_nxt)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_ticks_r   <= BIT_TICKS_RST;
      line_invert_r <= 1'b0;
      enable_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIT_TICKS:   bit_ticks_r   <= cfg_wdata[TIMER_W-1:0];
        CFG_LINE_INVERT: line_invert_r <= cfg_wdata[0];
        CFG_ENABLE:      enable_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      rx_phase_r <= RX_IDLE;
      rx_timer_r <= '0;
      rx_idx_r   <= '0;
      rx_shift_r <= '0;
      rx_prev_r  <= 1'b1;
      tx_phase_r <= TX_IDLE;
      tx_timer_r <= '0;
      tx_idx_r   <= '0;
      tx_shift_r <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      ovf_r      <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_vld_r <= in_valid;
      end
      if (s2_ready) begin
        out_vld_r <= s1_vld_r;
      end
      if (adv) begin
        out_data_r <= res;
        rx_phase_r <= rx_phase_nxt;
        rx_timer_r <= rx_timer_nxt;
        rx_idx_r   <= rx_idx_nxt;
        rx_shift_r <= rx_shift_nxt;
        rx_prev_r  <= rx_prev_nxt;
        tx_phase_r <= tx_phase_nxt;
        tx_timer_r <= tx_timer_nxt;
        tx_idx_r   <= tx_idx_nxt;
        tx_shift_r <= tx_shift_nxt;
        head_r     <= head_pop;
        tail_r     <= tail_nxt;
        ovf_r      <= ovf_nxt;
      end
    end
  end

endmodule
